[hdl/assert_macros.svh]
// assertion helpers used by the tracker datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// clocked assertion on the block clock and reset
`define ASSERT_DEF(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

[hdl/rot_pkg.sv]
package rot_pkg;

	localparam int CHUNK_BITS_DEF = 20;
	localparam int INDEX_BITS_DEF = 20;
	localparam int MAX_SPAN_DEF   = 64;

	localparam int ADDR_W    = 40;
	localparam int LEN_W     = 41;
	localparam int IDX_OUT_W = 20;
	localparam int STAT_W    = 2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SPAN  = 2'd2;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] idx;
		logic                 now_used;
		logic [STAT_W-1:0]    status;
		logic                 last;
	} res_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_en;
		logic load;
		logic calc_end;
		logic reject;
		logic rd;
		logic commit;
		logic flush;
	} ctl_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic len_zero;
		logic too_long;
		logic mod_ok;
		logic range_done;
		logic pend_valid;
		logic out_free;
	} ctl_sts_t;

endpackage

[hdl/rot_ram.sv]
module rot_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/rot_ctrl.sv]
module rot_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rot_pkg::ctl_sts_t  sts,
	output rot_pkg::ctl_cmd_t  cmd
);
	import rot_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_END   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_MOD   = 3'd5;
	localparam logic [2:0] S_FLUSH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_END;
				end
			end
			S_END: begin
				cmd.calc_end = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				if (sts.len_zero) begin
					state_d = S_IDLE;
				end else if (sts.too_long) begin
					cmd.reject = 1'b1;
					state_d    = S_FLUSH;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_MOD;
			end
			S_MOD: begin
				// hold while a new event cannot displace the pending one
				if (sts.mod_ok) begin
					cmd.commit = 1'b1;
					state_d    = sts.range_done ? S_FLUSH : S_RD;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/rot_dp.sv]
`include "assert_macros.svh"

module rot_dp #(
	parameter int CHUNK_BITS = rot_pkg::CHUNK_BITS_DEF,
	parameter int INDEX_BITS = rot_pkg::INDEX_BITS_DEF,
	parameter int MAX_SPAN   = rot_pkg::MAX_SPAN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rot_pkg::ctl_cmd_t             cmd,
	output rot_pkg::ctl_sts_t             sts,
	input  logic                          cmd_in,
	input  logic [rot_pkg::ADDR_W-1:0]    start_address,
	input  logic [rot_pkg::LEN_W-1:0]     byte_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rot_pkg::IDX_OUT_W-1:0] chunk_index,
	output logic                          now_used,
	output logic [rot_pkg::STAT_W-1:0]    status,
	output logic                          last
);
	import rot_pkg::*;

	localparam int ABITS = CHUNK_BITS + INDEX_BITS;
	localparam int EW    = ((ABITS > LEN_W) ? ABITS : LEN_W) + 1;
	localparam int CW    = CHUNK_BITS + 1;

	logic             release_q;
	logic [ABITS-1:0] beg_q;
	logic [LEN_W-1:0] len_q;
	logic [ABITS:0]   end_q;
	logic [ABITS:0]   stop_q;
	logic [CW-1:0]    use_q;
	logic [INDEX_BITS-1:0] clr_q;

	logic pend_valid_q;
	res_t pend_res_q;
	logic out_valid_q;
	res_t out_res_q;

	// range end, clipped at the window end
	logic [EW-1:0]  sum_w;
	logic [EW-1:0]  win_w;
	logic [ABITS:0] end_d;

	always_comb begin
		sum_w = EW'(beg_q) + EW'(len_q);
		win_w = {{(EW-1){1'b0}}, 1'b1} << ABITS;
		end_d = (sum_w > win_w) ? win_w[ABITS:0] : sum_w[ABITS:0];
	end

	// span check
	logic [ABITS:0]        end_m1;
	logic [INDEX_BITS-1:0] first_idx;
	logic [INDEX_BITS-1:0] last_idx;
	logic [INDEX_BITS-1:0] span_m1;

	always_comb begin
		end_m1    = end_q - (ABITS+1)'(1);
		first_idx = beg_q[ABITS-1:CHUNK_BITS];
		last_idx  = end_m1[ABITS-1:CHUNK_BITS];
		span_m1   = last_idx - first_idx;
	end

	// piece of the range inside the current chunk
	logic [ABITS:0] bnd;
	logic [ABITS:0] stop_d;
	logic [ABITS:0] use_full;

	always_comb begin
		bnd      = {1'b0, first_idx, {CHUNK_BITS{1'b0}}}
		           + ((ABITS+1)'(1) << CHUNK_BITS);
		stop_d   = (bnd < end_q) ? bnd : end_q;
		use_full = stop_d - {1'b0, beg_q};
	end

	// count update
	logic [CW-1:0] cnt;
	logic [CW-1:0] chunk_w;
	logic [CW:0]   sum_c;
	logic          under;
	logic [CW-1:0] new_cnt;
	logic          ev;
	res_t          ev_res;

	always_comb begin
		chunk_w         = CW'(1) << CHUNK_BITS;
		sum_c           = {1'b0, cnt} + {1'b0, use_q};
		under           = cnt < use_q;
		ev_res.idx      = IDX_OUT_W'(first_idx);
		ev_res.last     = 1'b0;
		ev_res.now_used = 1'b0;
		ev_res.status   = STAT_OK;
		if (!release_q) begin
			new_cnt         = (sum_c > {1'b0, chunk_w}) ? chunk_w : sum_c[CW-1:0];
			ev              = (cnt == '0);
			ev_res.now_used = 1'b1;
		end else if (under) begin
			new_cnt       = '0;
			ev            = 1'b1;
			ev_res.status = STAT_UNDER;
		end else begin
			new_cnt = cnt - use_q;
			ev      = (new_cnt == '0);
		end
	end

	logic out_free;
	logic push;
	res_t rej_res;

	assign out_free = !out_valid_q || out_ready;
	assign push     = (cmd.commit && ev && pend_valid_q) || cmd.flush;

	always_comb begin
		rej_res.idx      = IDX_OUT_W'(first_idx);
		rej_res.now_used = 1'b0;
		rej_res.status   = STAT_SPAN;
		rej_res.last     = 1'b0;
	end

	// chunk count store
	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [CW-1:0]         wr_data;

	assign wr_en   = cmd.clr_en || cmd.commit;
	assign wr_addr = cmd.clr_en ? clr_q : first_idx;
	assign wr_data = cmd.clr_en ? '0 : new_cnt;

	rot_ram #(
		.WIDTH (CW),
		.DEPTH (1 << INDEX_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (first_idx),
		.rd_data (cnt)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			release_q <= cmd_in;
			beg_q     <= ABITS'(start_address);
			len_q     <= byte_length;
		end else if (cmd.commit) begin
			beg_q <= stop_q[ABITS-1:0];
		end
		if (cmd.calc_end) begin
			end_q <= end_d;
		end
		if (cmd.rd) begin
			stop_q <= stop_d;
			use_q  <= use_full[CW-1:0];
		end
		if (cmd.reject) begin
			pend_res_q <= rej_res;
		end else if (cmd.commit && ev) begin
			pend_res_q <= ev_res;
		end
		if (push) begin
			out_res_q <= '{idx: pend_res_q.idx, now_used: pend_res_q.now_used,
				status: pend_res_q.status, last: cmd.flush};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + INDEX_BITS'(1);
			if (cmd.reject || (cmd.commit && ev)) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clr_last   = (clr_q == '1);
		sts.len_zero   = (len_q == '0);
		sts.too_long   = (span_m1 >= INDEX_BITS'(MAX_SPAN));
		sts.mod_ok     = !ev || !pend_valid_q || out_free;
		sts.range_done = (stop_q == end_q);
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	assign out_valid   = out_valid_q;
	assign chunk_index = out_res_q.idx;
	assign now_used    = out_res_q.now_used;
	assign status      = out_res_q.status;
	assign last        = out_res_q.last;

	`ASSERT_DEF(a_push_slot_free, push |-> out_free, "result pushed into a full output slot")
	`ASSERT_DEF(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
	`ASSERT_DEF(a_cnt_bounded, cmd.commit |-> (new_cnt <= chunk_w), "chunk count above chunk size")
	`ASSERT_DEF(a_used_is_ok, out_valid_q |-> (!out_res_q.now_used || out_res_q.status == STAT_OK), "used event with a fault status")
	`ASSERT_DEF(a_span_is_last, (out_valid_q && out_res_q.status == STAT_SPAN) |-> out_res_q.last, "rejected request not marked last")

endmodule

[hdl/region_occupancy_tracker.sv]
// each request is loaded, its range end computed and its span checked (a zero length ends
// here, a too-long span is rejected); then each touched chunk takes a store read, then an
// update and write, and any pending final result is handed out last; a new request is taken
// only once the last is done, later while the result side stalls; the registered store read
// ahead of each update sets the chunk rate. reset: async active low; a clearing pass then
// zeroes the whole store with in_ready low
module region_occupancy_tracker #(
	parameter int CHUNK_BITS = rot_pkg::CHUNK_BITS_DEF,
	parameter int INDEX_BITS = rot_pkg::INDEX_BITS_DEF,
	parameter int MAX_SPAN   = rot_pkg::MAX_SPAN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [rot_pkg::ADDR_W-1:0]    start_address,
	input  logic [rot_pkg::LEN_W-1:0]     byte_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rot_pkg::IDX_OUT_W-1:0] chunk_index,
	output logic                          now_used,
	output logic [rot_pkg::STAT_W-1:0]    status,
	output logic                          last
);
	import rot_pkg::*;

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;

	rot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	rot_dp #(
		.CHUNK_BITS (CHUNK_BITS),
		.INDEX_BITS (INDEX_BITS),
		.MAX_SPAN   (MAX_SPAN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.sts           (ctl_sts),
		.cmd_in        (cmd),
		.start_address (start_address),
		.byte_length   (byte_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chunk_index   (chunk_index),
		.now_used      (now_used),
		.status        (status),
		.last          (last)
	);

endmodule

[test/tb_region_occupancy_tracker.sv]
module tb_region_occupancy_tracker;
	import rot_pkg::*;

	localparam int CHUNK_LOG  = CHUNK_BITS_DEF;
	localparam int INDEX_LOG  = INDEX_BITS_DEF;
	localparam int SPAN_LIMIT = MAX_SPAN_DEF;
	localparam longint unsigned CHUNK_BYTES  = 64'd1 << CHUNK_LOG;
	localparam longint unsigned WINDOW_BYTES = 64'd1 << (CHUNK_LOG + INDEX_LOG);
	localparam longint unsigned NUM_CHUNKS   = 64'd1 << INDEX_LOG;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// the clearing pass after reset accepts no request
	localparam int WATCHDOG_LIMIT = 2 * (1 << INDEX_LOG) + 20000;
	localparam int DRAIN_CYCLES   = 2 * (4 + 2 * SPAN_LIMIT);
	localparam int HOLD_CYCLES    = 600;

	typedef struct {
		longint unsigned addr;
		longint unsigned len;
	} region_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd = 1'b0;
	logic [ADDR_W-1:0]    start_address = '0;
	logic [LEN_W-1:0]     byte_length = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [IDX_OUT_W-1:0] chunk_index;
	logic                 now_used;
	logic [STAT_W-1:0]    status;
	logic                 last;

	bit [CHUNK_LOG:0] chunk_fill [NUM_CHUNKS];
	res_t             expected_events[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int events_checked = 0;
	int underflows_seen = 0;
	int rejects_seen = 0;

	region_occupancy_tracker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.start_address(start_address),
		.byte_length  (byte_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_index  (chunk_index),
		.now_used     (now_used),
		.status       (status),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic res_t make_event(longint unsigned idx, logic used, logic [STAT_W-1:0] st);
		res_t ev;
		ev.idx      = IDX_OUT_W'(idx);
		ev.now_used = used;
		ev.status   = st;
		ev.last     = 1'b0;
		return ev;
	endfunction

	// splits the range at chunk boundaries and queues the status changes it causes
	function automatic void predict_chunk_events(logic op, longint unsigned addr,
		longint unsigned len);
		longint unsigned lo, hi, first_chunk, span, boundary, seg_end, used, fill, idx;
		res_t ev;
		res_t evs[$];
		lo = addr & (WINDOW_BYTES - 1);
		len = len & ((64'd1 << LEN_W) - 1);
		if (len == 0)
			return;
		hi = lo + len;
		if (hi > WINDOW_BYTES)
			hi = WINDOW_BYTES;
		first_chunk = lo >> CHUNK_LOG;
		span = ((hi - 1) >> CHUNK_LOG) - first_chunk + 1;
		if (span > SPAN_LIMIT) begin
			ev = make_event(first_chunk, 1'b0, STAT_SPAN);
			ev.last = 1'b1;
			expected_events.push_back(ev);
			return;
		end
		while (lo < hi) begin
			idx = (lo >> CHUNK_LOG) & (NUM_CHUNKS - 1);
			boundary = (lo | (CHUNK_BYTES - 1)) + 1;
			seg_end = boundary < hi ? boundary : hi;
			used = seg_end - lo;
			fill = chunk_fill[idx];
			if (op == OP_ALLOC) begin
				if (fill == 0)
					evs.push_back(make_event(idx, 1'b1, STAT_OK));
				fill += used;
				if (fill > CHUNK_BYTES)
					fill = CHUNK_BYTES;
			end else if (fill < used) begin
				// clamps even when the chunk was already empty
				fill = 0;
				evs.push_back(make_event(idx, 1'b0, STAT_UNDER));
			end else begin
				fill -= used;
				if (fill == 0)
					evs.push_back(make_event(idx, 1'b0, STAT_OK));
			end
			chunk_fill[idx] = (CHUNK_LOG + 1)'(fill);
			lo = seg_end;
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].last = 1'b1;
		foreach (evs[k])
			expected_events.push_back(evs[k]);
	endfunction

	task automatic send_request(input logic op, input longint unsigned addr,
		input longint unsigned len);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= op;
		start_address <= ADDR_W'(addr);
		byte_length   <= LEN_W'(len);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_chunk_events(op, addr, len);
		requests_sent++;
	endtask

	function automatic longint unsigned random_addr();
		return (longint'($urandom_range(255)) << 32) | longint'($urandom);
	endfunction

	// result side: checks each accepted result, idles at random or holds off on request
	always @(posedge clk) begin : result_check
		res_t exp_ev;
		if (out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: idx %0d used %0b status %0d last %0b",
						chunk_index, now_used, status, last);
			end else begin
				exp_ev = expected_events.pop_front();
				events_checked++;
				if (exp_ev.status == STAT_UNDER)
					underflows_seen++;
				if (exp_ev.status == STAT_SPAN)
					rejects_seen++;
				if (chunk_index !== exp_ev.idx || now_used !== exp_ev.now_used ||
					status !== exp_ev.status || last !== exp_ev.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected idx %0d used %0b status %0d last %0b, %s",
							exp_ev.idx, exp_ev.now_used, exp_ev.status, exp_ev.last,
							$sformatf("got idx %0d used %0b status %0d last %0b",
							chunk_index, now_used, status, last));
				end
			end
		end
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_directed_edges();
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_RELEASE, 40'h12_3456_7890, 0);
		send_request(OP_ALLOC, 0, 1);
		// second allocation saturates the count at a full chunk
		send_request(OP_ALLOC, 0, CHUNK_BYTES);
		send_request(OP_RELEASE, 0, CHUNK_BYTES);
		send_request(OP_RELEASE, 0, 1);
		send_request(OP_ALLOC, 5 * CHUNK_BYTES, 300);
		send_request(OP_RELEASE, 5 * CHUNK_BYTES + 100, 1000);
		send_request(OP_ALLOC, 8 * CHUNK_BYTES - 1, 2);
		send_request(OP_RELEASE, 8 * CHUNK_BYTES - 1, 2);
		send_request(OP_ALLOC, 64 * CHUNK_BYTES, SPAN_LIMIT * CHUNK_BYTES);
		send_request(OP_RELEASE, 64 * CHUNK_BYTES, SPAN_LIMIT * CHUNK_BYTES);
		send_request(OP_ALLOC, 64 * CHUNK_BYTES, (SPAN_LIMIT + 1) * CHUNK_BYTES);
		send_request(OP_ALLOC, 64 * CHUNK_BYTES + 1, SPAN_LIMIT * CHUNK_BYTES);
		send_request(OP_ALLOC, 0, WINDOW_BYTES);
		// clipped at the window end down to the last byte
		send_request(OP_ALLOC, WINDOW_BYTES - 1, WINDOW_BYTES);
		send_request(OP_ALLOC, WINDOW_BYTES - 10, 100);
		send_request(OP_RELEASE, WINDOW_BYTES - SPAN_LIMIT * CHUNK_BYTES, WINDOW_BYTES);
		send_request(OP_RELEASE, WINDOW_BYTES - (SPAN_LIMIT + 1) * CHUNK_BYTES, WINDOW_BYTES);
		send_request(OP_ALLOC, WINDOW_BYTES - 1, 1);
		send_request(OP_RELEASE, WINDOW_BYTES - 1, 1);
	endtask

	// mostly allocations and matching releases around a few hot chunks
	task automatic test_random_traffic(input int count, input longint unsigned hot_chunk);
		region_t live[$];
		region_t blk;
		longint unsigned addr, len;
		logic op;
		int counted, pick, len_pick, slot;
		counted = 0;
		while (counted < count) begin
			pick = $urandom_range(99);
			addr = ((hot_chunk + $urandom_range(15)) << CHUNK_LOG) & (WINDOW_BYTES - 1);
			if ($urandom_range(3) != 0)
				addr += $urandom_range(32'(CHUNK_BYTES - 1));
			len_pick = $urandom_range(9);
			if (len_pick < 6)
				len = $urandom_range(32'(2 * CHUNK_BYTES), 1);
			else if (len_pick < 8)
				len = $urandom_range(4096, 1);
			else if (len_pick == 8)
				len = CHUNK_BYTES * $urandom_range(4, 1);
			else
				len = CHUNK_BYTES * $urandom_range(SPAN_LIMIT - 1, 1);
			op = OP_ALLOC;
			if (pick < 45 || (pick < 80 && live.size() == 0)) begin
				blk.addr = addr;
				blk.len = len;
				live.push_back(blk);
				if (live.size() > 32)
					void'(live.pop_front());
			end else if (pick < 80) begin
				slot = $urandom_range(live.size() - 1);
				blk = live[slot];
				live.delete(slot);
				op = OP_RELEASE;
				addr = blk.addr;
				len = blk.len;
			end else if (pick < 88) begin
				op = OP_RELEASE;
			end else if (pick < 92) begin
				len = CHUNK_BYTES * (SPAN_LIMIT + $urandom_range(200, 1));
				op = logic'($urandom_range(1));
			end else if (pick < 95) begin
				len = 0;
				op = logic'($urandom_range(1));
				addr = random_addr();
			end else begin
				addr = random_addr();
				len = random_addr() >> $urandom_range(39);
				op = logic'($urandom_range(1));
			end
			send_request(op, addr, len);
			if (len != 0)
				counted++;
		end
	endtask

	// results pile up behind a long hold-off until the input side stalls
	task automatic test_output_backpressure();
		int saved_idle;
		longint unsigned base;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		base = $urandom_range(32'(NUM_CHUNKS - 128));
		hold_asks++;
		for (int k = 0; k < 24; k++)
			send_request(OP_ALLOC, (base + 2 * k) << CHUNK_LOG, 2 * CHUNK_BYTES);
		for (int k = 0; k < 24; k++)
			send_request(OP_RELEASE, (base + 2 * k) << CHUNK_LOG, 2 * CHUNK_BYTES);
		send_idle_pct = saved_idle;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 19;
		recv_idle_pct = 71;
		test_directed_edges();
		test_random_traffic(110, $urandom_range(32'(NUM_CHUNKS - 1)));
		test_output_backpressure();

		send_idle_pct = 71;
		recv_idle_pct = 19;
		test_random_traffic(110, NUM_CHUNKS - 12);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(110, $urandom_range(32'(NUM_CHUNKS - 1)));

		in_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (alloc, release, clipping, saturation, back-pressure)",
			requests_sent);
		$display("checked %0d chunk events: %0d underflow clamps, %0d rejected spans",
			events_checked, underflows_seen, rejects_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
